// ===== sv/sd4c_pkg.sv =====
// Shared types, constants and CRC functions for the four-lane SD CRC16 unit.
package sd4c_pkg;

	localparam int LANES       = 4;
	localparam int CRC_W       = 16;
	localparam int CRC_BYTES   = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	typedef logic [CRC_W-1:0] lane_crc_t;
	typedef logic [LANES-1:0][CRC_W-1:0] crc_set_t;
	typedef logic [$clog2(CRC_BYTES)-1:0] byte_idx_t;

	// Queue status seen by the producer and the consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Shift one data bit into one lane register.
	function automatic lane_crc_t crc_step(lane_crc_t r, logic b);
		lane_crc_t nxt;
		nxt = {r[CRC_W-2:0], 1'b0};
		if (r[CRC_W-1] ^ b) begin
			nxt = nxt ^ CRC_POLY;
		end
		return nxt;
	endfunction

	// Feed one nibble: bit 3 to lane 0 down to bit 0 to lane 3.
	function automatic crc_set_t crc_nibble(crc_set_t s, logic [LANES-1:0] nib);
		crc_set_t r;
		r = s;
		for (int l = 0; l < LANES; l++) begin
			r[l] = crc_step(s[l], nib[LANES-1-l]);
		end
		return r;
	endfunction

	// Output word k: bit 15-2k of lanes 0..3, then bit 14-2k of lanes 0..3.
	function automatic logic [7:0] crc_out_byte(crc_set_t s, byte_idx_t k);
		logic [3:0] hi;
		logic [3:0] lo;
		logic [7:0] b;
		hi = {~k, 1'b1};
		lo = {~k, 1'b0};
		b  = '0;
		for (int l = 0; l < LANES; l++) begin
			b[7-l] = s[l][hi];
			b[3-l] = s[l][lo];
		end
		return b;
	endfunction

endpackage

// ===== sv/sd4c_in_if.sv =====
// Input channel: one sector byte per word with a last-byte mark.
interface sd4c_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// ===== sv/sd4c_out_if.sv =====
// Output channel: one interleaved CRC byte per word with an end mark.
interface sd4c_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] crc_byte;
	logic       crc_last;

	modport source(output valid, crc_byte, crc_last, input ready);
	modport sink(input valid, crc_byte, crc_last, output ready);
endinterface

// ===== sv/sd_four_lane_crc16_unit.sv =====
// Top level of the four-lane SD data CRC16 unit.
// Usage:
//   data channel (sink): one sector byte per word, data_byte with last_byte
//   marking the final byte of a block. The high nibble feeds first; bits 7
//   and 3 go to DAT0, bits 6 and 2 to DAT1, bits 5 and 1 to DAT2, 4 and 0 to DAT3.
//   crc channel (source): after each last byte, eight words carry the four
//   CRC16-CCITT values interleaved MSB first, two bit positions per word;
//   crc_last marks the eighth.
// Timing:
//   Bytes are taken one per cycle while the queue has room; the front end
//   runs both nibble updates of all four lanes in a single step.
//   On the last byte the lane set is written into the queue; the back end,
//   once free, pops it into its output register, which then holds the first
//   CRC word, and the rest follow one per cycle while the receiver is ready.
//   The front end stalls (ready low) only while the queue of finished
//   blocks is full, so back-to-back sectors of eight bytes or more stream
//   without a bubble.
// Reset: arst_n clears the lane CRCs, empties the queue and clears the output valid flag.
// Receiver stall: the current CRC word holds; the front end keeps taking
// bytes until QUEUE_DEPTH_P finished blocks are waiting.
module sd_four_lane_crc16_unit
	import sd4c_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sd4c_in_if.sink    data,
	sd4c_out_if.source crc
);

	// Queue handshake between front and back.
	logic     push;
	logic     pop;
	crc_set_t push_data;
	crc_set_t head;
	q_stat_t  qs;

	// Front: absorb bytes, post the finished lane set on the last byte.
	sd4c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data      (data),
		.qs        (qs),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple: hold finished blocks while the receiver stalls.
	sd4c_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qs        (qs)
	);

	// Back: emit eight interleaved words per block.
	sd4c_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qs     (qs),
		.pop    (pop),
		.crc    (crc)
	);

`ifndef NO_ASSERTIONS
	a_q_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(qs.full && qs.empty))
		else $error("queue reports full and empty at once");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty)
		else $error("back end popped an empty queue");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		data.valid && data.ready && data.last_byte |=> !qs.empty)
		else $error("finished block not queued after last byte");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qs.full)
		else $error("front end pushed into a full queue");
`endif

endmodule

// ===== sv/sd4c_front.sv =====
// Front end: absorbs sector bytes into the four lane CRCs, posts the result on the last byte.
module sd4c_front
	import sd4c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sd4c_in_if.sink   data,
	input  q_stat_t   qs,
	output logic      push,
	output crc_set_t  push_data
);

	crc_set_t crc_q;
	crc_set_t crc_hi;
	logic     take;

	// Stall only when the queue cannot take a finished sector.
	assign data.ready = !qs.full;
	assign take       = data.valid && data.ready;

	always_comb begin
		crc_hi    = crc_nibble(crc_q, data.data_byte[7:4]);
		push_data = crc_nibble(crc_hi, data.data_byte[3:0]);
	end

	assign push = take && data.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (take) begin
			crc_q <= data.last_byte ? crc_set_t'('0) : push_data;
		end
	end

endmodule

// ===== sv/sd4c_queue.sv =====
// Small FIFO of finished CRC sets between front and back.
module sd4c_queue
	import sd4c_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  crc_set_t push_data,
	input  logic     pop,
	output crc_set_t head,
	output q_stat_t  qs
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	crc_set_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign head     = mem_q[rd_ptr_q];
	assign qs.full  = (cnt_q == CW'(DEPTH));
	assign qs.empty = (cnt_q == '0);

	function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/sd4c_back.sv =====
// Back end: serializes one CRC set into eight interleaved bytes through an output register.
module sd4c_back
	import sd4c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  crc_set_t  head,
	input  q_stat_t   qs,
	output logic      pop,
	sd4c_out_if.source crc
);

	crc_set_t   hold_q;
	byte_idx_t  idx_q;
	logic       busy_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       adv;

	// Advance when the output register is free or being taken.
	assign adv = !out_v_q || crc.ready;
	assign pop = adv && !busy_q && !qs.empty;

	assign crc.valid    = out_v_q;
	assign crc.crc_byte = out_byte_q;
	assign crc.crc_last = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q     <= head;
			out_byte_q <= crc_out_byte(head, '0);
			out_last_q <= 1'b0;
		end else if (adv && busy_q) begin
			out_byte_q <= crc_out_byte(hold_q, idx_q);
			out_last_q <= (idx_q == byte_idx_t'(CRC_BYTES - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				out_v_q <= 1'b1;
				idx_q   <= idx_q + 1'b1;
				if (idx_q == byte_idx_t'(CRC_BYTES - 1)) begin
					busy_q <= 1'b0;
				end
			end else if (pop) begin
				out_v_q <= 1'b1;
				idx_q   <= byte_idx_t'(1);
				busy_q  <= 1'b1;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
